[src/ils_pkg.sv]
`timescale 1ns / 1ps

package ils_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned REQ_W   = 3;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned COUNT_W = 7;

    // s-side word: req_type, position, data_in; m-side word: data_out, status, count
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ       = 3'd0,
        REQ_WRITE      = 3'd1,
        REQ_INSERT     = 3'd2,
        REQ_DELETE     = 3'd3,
        REQ_PUSH_FRONT = 3'd4,
        REQ_PUSH_BACK  = 3'd5
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_LOW    = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BEYOND = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [WORD_W-1:0] word;
    } t_cell_ctl;

    typedef struct packed {
        logic    rd_en;
        t_status status;
    } t_ctl_rsp;

endpackage

[src/ils_cell.sv]
`timescale 1ns / 1ps

module ils_cell #(
    parameter int unsigned IW  = 6,
    parameter int unsigned IDX = 0
) (
    input  logic                              i_clk,
    input  ils_pkg::t_cell_ctl                i_ctl,
    input  logic [IW-1:0]                     i_at,
    input  logic [ils_pkg::WORD_W-1:0]        i_left,
    input  logic [ils_pkg::WORD_W-1:0]        i_right,
    output logic [ils_pkg::WORD_W-1:0]        o_q
);

    logic [ils_pkg::WORD_W-1:0] r_q;
    logic [ils_pkg::WORD_W-1:0] n_q;
    logic                       w_here;
    logic                       w_above;

    assign w_here  = (i_at == IW'(IDX));
    assign w_above = (IW'(IDX) > i_at);

    always_comb begin
        n_q = r_q;
        case (i_ctl.op)
            ils_pkg::CELL_WRITE: begin
                if (w_here) n_q = i_ctl.word;
            end
            ils_pkg::CELL_INSERT: begin
                if (w_here) n_q = i_ctl.word;
                else if (w_above) n_q = i_left;
            end
            ils_pkg::CELL_DELETE: begin
                if (w_here || w_above) n_q = i_right;
            end
            default: n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

[src/ils_ctrl.sv]
`timescale 1ns / 1ps

module ils_ctrl #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IW    = 6,
    parameter int unsigned CW    = 7
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  logic [ils_pkg::REQ_W-1:0]        i_req,
    input  logic [ils_pkg::POS_W-1:0]        i_pos,
    input  logic [ils_pkg::WORD_W-1:0]       i_word,
    output ils_pkg::t_cell_ctl               o_ctl,
    output logic [IW-1:0]                    o_at,
    output ils_pkg::t_ctl_rsp                o_rsp,
    output logic [CW-1:0]                    o_count
);

    localparam int unsigned CMPW = ((CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W) + 1;

    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic [CMPW-1:0]  w_p;
    logic [CMPW-1:0]  w_n;
    logic [CMPW-1:0]  w_n1;
    logic [IW-1:0]    w_p_m1;
    logic             w_p0;
    logic             w_n0;
    logic             w_full;
    ils_pkg::t_status w_st;
    ils_pkg::t_cell_op w_op;
    logic [IW-1:0]    w_at;
    logic             w_rd;

    assign w_p    = CMPW'(i_pos);
    assign w_n    = CMPW'(r_cnt);
    assign w_n1   = w_n + CMPW'(1);
    assign w_p_m1 = IW'(w_p - CMPW'(1));
    assign w_p0   = (w_p == '0);
    assign w_n0   = (w_n == '0);
    assign w_full = (w_n >= CMPW'(DEPTH));

    always_comb begin
        w_st  = ils_pkg::ST_OK;
        w_op  = ils_pkg::CELL_HOLD;
        w_at  = w_p_m1;
        w_rd  = 1'b0;
        n_cnt = r_cnt;
        case (ils_pkg::t_req'(i_req))
            ils_pkg::REQ_READ: begin
                if (w_p0) w_st = ils_pkg::ST_LOW;
                else if (w_n0) w_st = ils_pkg::ST_EMPTY;
                else if (w_p > w_n) w_st = ils_pkg::ST_BEYOND;
                else w_rd = 1'b1;
            end
            ils_pkg::REQ_WRITE: begin
                if (w_p > w_n) w_st = ils_pkg::ST_BEYOND;
                else if (w_p0) w_st = ils_pkg::ST_LOW;
                else w_op = ils_pkg::CELL_WRITE;
            end
            ils_pkg::REQ_INSERT: begin
                if ((w_p != w_n1) && (w_p > w_n)) w_st = ils_pkg::ST_BEYOND;
                else if (w_p0) w_st = ils_pkg::ST_LOW;
                else if (w_full) w_st = ils_pkg::ST_FULL;
                else begin
                    w_op  = ils_pkg::CELL_INSERT;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ils_pkg::REQ_DELETE: begin
                if (w_p > w_n) w_st = ils_pkg::ST_BEYOND;
                else if (w_n0) w_st = ils_pkg::ST_EMPTY;
                else if (w_p0) w_st = ils_pkg::ST_LOW;
                else begin
                    w_op  = ils_pkg::CELL_DELETE;
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ils_pkg::REQ_PUSH_FRONT: begin
                w_at = '0;
                if (w_full) w_st = ils_pkg::ST_FULL;
                else begin
                    w_op  = ils_pkg::CELL_INSERT;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ils_pkg::REQ_PUSH_BACK: begin
                w_at = IW'(r_cnt);
                if (w_full) w_st = ils_pkg::ST_FULL;
                else begin
                    w_op  = ils_pkg::CELL_INSERT;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            default: w_st = ils_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_fire) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_ctl.op     = i_fire ? w_op : ils_pkg::CELL_HOLD;
    assign o_ctl.word   = i_word;
    assign o_at         = w_at;
    assign o_rsp.rd_en  = w_rd;
    assign o_rsp.status = w_st;
    assign o_count      = n_cnt;

endmodule

[src/indexed_list_store.sv]
`timescale 1ns / 1ps

// Ordered list of up to DEPTH 32-bit words addressed by 1-based position,
// held in a row of cells that shift together on insert and delete. Each
// request word (read, write, insert, delete, push front, push back) gives
// exactly one response word with the word read, a status and the count
// after the request; failed requests change nothing. A request is decoded
// and applied to every cell at the accepting edge and its response lands
// in the output register, so one request per cycle is sustained while the
// response side keeps up. Counts above 127 wrap in the 7-bit count field.

module indexed_list_store #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ils_pkg::S_DATA_W-1:0]     i_s_tdata,   // req_type, position, data_in
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ils_pkg::M_DATA_W-1:0]     o_m_tdata    // data_out, status, count
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic                              w_fire;
    logic [ils_pkg::REQ_W-1:0]         w_req;
    logic [ils_pkg::POS_W-1:0]         w_pos;
    logic [ils_pkg::WORD_W-1:0]        w_word;
    ils_pkg::t_cell_ctl                w_ctl;
    logic [IW-1:0]                     w_at;
    ils_pkg::t_ctl_rsp                 w_rsp;
    logic [CW-1:0]                     w_count;
    logic [ils_pkg::WORD_W-1:0]        w_q [DEPTH];
    logic [ils_pkg::WORD_W-1:0]        w_rd;

    logic                              r_out_valid;
    logic [ils_pkg::M_DATA_W-1:0]      r_out_data;

    assign w_req  = i_s_tdata[ils_pkg::REQ_W-1:0];
    assign w_pos  = i_s_tdata[ils_pkg::REQ_W +: ils_pkg::POS_W];
    assign w_word = i_s_tdata[ils_pkg::REQ_W + ils_pkg::POS_W +: ils_pkg::WORD_W];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_fire     = i_s_tvalid && o_s_tready;

    ils_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (w_req),
        .i_pos   (w_pos),
        .i_word  (w_word),
        .o_ctl   (w_ctl),
        .o_at    (w_at),
        .o_rsp   (w_rsp),
        .o_count (w_count)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ils_pkg::WORD_W-1:0] w_left;
        logic [ils_pkg::WORD_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_q[g];
        end else begin : g_inner
            assign w_right = w_q[g+1];
        end
        ils_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_at    (w_at),
            .i_left  (w_left),
            .i_right (w_right),
            .o_q     (w_q[g])
        );
    end

    assign w_rd = w_rsp.rd_en ? w_q[w_at] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {
                (ils_pkg::M_DATA_W - ils_pkg::WORD_W - ils_pkg::STAT_W - ils_pkg::COUNT_W)'(0),
                ils_pkg::COUNT_W'(w_count),
                w_rsp.status,
                w_rd
            };
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
